### sv/lfu_pkg.sv
// Package for the LFU cache: beat types, rank record, key table write controls,
// sequencer states and shared constants. No dependencies.
`timescale 1ns / 1ps

package lfu_pkg;

  localparam logic        CMD_GET    = 1'b0;
  localparam logic        CMD_PUT    = 1'b1;
  localparam logic [31:0] SAT_MAX    = 32'hFFFF_FFFF;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam int unsigned KEY_BITS   = 12;

  typedef struct packed {
    logic               command;
    logic [11:0]        key;
    logic signed [31:0] value;
  } lfu_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } lfu_out_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] stamp;
  } lfu_rank_t;

  typedef struct packed {
    logic valid_we;
    logic valid;
    logic value_we;
    logic slot_we;
  } lfu_kt_wr_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_LK_RD,
    ST_LK_CHK,
    ST_TOUCH,
    ST_EV_RD,
    ST_EV_V,
    ST_EV_L,
    ST_INS,
    ST_SK_C,
    ST_SK_L,
    ST_SK_R,
    ST_SK_CMP,
    ST_SK_END,
    ST_RS_C,
    ST_RS_P,
    ST_RS_END
  } lfu_state_e;

endpackage

### sv/lfu_rank_cmp.sv
// Shared rank comparator: orders two heap entries on (count, stamp).
// Depends on lfu_pkg.
`timescale 1ns / 1ps

module lfu_rank_cmp
  import lfu_pkg::*;
(
  input  lfu_rank_t a_i,
  input  lfu_rank_t b_i,
  output logic      below_o
);

  always_comb begin
    if (a_i.count != b_i.count) begin
      below_o = a_i.count < b_i.count;
    end else begin
      below_o = a_i.stamp < b_i.stamp;
    end
  end

endmodule

### sv/lfu_key_table.sv
// Key table: valid flag, value and heap slot per key, one address per cycle,
// registered read. Depends on lfu_pkg.
`timescale 1ns / 1ps

module lfu_key_table
  import lfu_pkg::*;
#(
  parameter int unsigned KEY_SPACE = 4096,
  parameter int unsigned KW        = 12,
  parameter int unsigned HW        = 6
) (
  input  logic          clk_i,
  input  logic [KW-1:0] addr_i,
  input  lfu_kt_wr_t    wr_i,
  input  logic [31:0]   value_i,
  input  logic [HW-1:0] slot_i,
  output logic          valid_o,
  output logic [31:0]   value_o,
  output logic [HW-1:0] slot_o
);

  logic          valid_mem [KEY_SPACE];
  logic [31:0]   value_mem [KEY_SPACE];
  logic [HW-1:0] slot_mem  [KEY_SPACE];

  always_ff @(posedge clk_i) begin
    if (wr_i.valid_we) begin
      valid_mem[addr_i] <= wr_i.valid;
    end
    valid_o <= valid_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.value_we) begin
      value_mem[addr_i] <= value_i;
    end
    value_o <= value_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.slot_we) begin
      slot_mem[addr_i] <= slot_i;
    end
    slot_o <= slot_mem[addr_i];
  end

endmodule

### sv/lfu_heap_ram.sv
// Heap storage: key and (count, stamp) per slot, single port, registered read.
// Depends on lfu_pkg.
`timescale 1ns / 1ps

module lfu_heap_ram
  import lfu_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned KW    = 12
) (
  input  logic          clk_i,
  input  logic [AW-1:0] addr_i,
  input  logic          we_i,
  input  logic [KW-1:0] key_i,
  input  lfu_rank_t     rank_i,
  output logic [KW-1:0] key_o,
  output lfu_rank_t     rank_o
);

  logic [KW-1:0] key_mem  [DEPTH];
  lfu_rank_t     rank_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[addr_i]  <= key_i;
      rank_mem[addr_i] <= rank_i;
    end
    key_o  <= key_mem[addr_i];
    rank_o <= rank_mem[addr_i];
  end

endmodule

### sv/lfu_cache_heap.sv
// LFU cache top level: capacity register, sequencer and datapath around the
// key table, the heap memory and the shared rank comparator.
// Depends on lfu_pkg, lfu_rank_cmp, lfu_key_table, lfu_heap_ram.
//
// Usage: drive cmd_i and raise start while busy is low; the beat is taken
// at that edge. A get gives one result beat on result_o, marked by
// result_valid_o for one cycle, in ST_LK_CHK after the key table read in
// ST_LK_RD (keys beyond the key space first pass through ST_MOD). A put
// gives no result. busy stays high until the heap update ends: a get or
// put of a present key sinks that key down the heap; a put of a new key,
// when the heap is full, first evicts the root and sinks the last entry in
// its place, then inserts the key at the end and raises it. The heap memory
// port takes one access a cycle.
// The receiver cannot stall: results are not held.
// cfg_data_i sets the capacity; cfg_ready_o is always high; write it only
// while busy is low. After reset busy stays high while the valid flags of
// all keys are cleared; capacity resets to 64.
`timescale 1ns / 1ps

module lfu_cache_heap
  import lfu_pkg::*;
#(
  parameter int unsigned KEY_SPACE  = 4096,
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  lfu_in_t    cmd_i,
  output logic       result_valid_o,
  output lfu_out_t   result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  localparam int unsigned KW  = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
  localparam int unsigned HW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CW  = HW + 2;
  localparam int unsigned PW  = (FW > 7) ? FW : 7;
  localparam int unsigned MOD_SHIFT = KEY_BITS + $clog2(KEY_SPACE);
  localparam logic [31:0] RECIP =
    32'(((64'd1 << MOD_SHIFT) + 64'(KEY_SPACE) - 64'd1) / 64'(KEY_SPACE));
  localparam logic [KW-1:0] CLR_LAST = KW'(KEY_SPACE - 1);

  lfu_state_e state_q, state_d;

  logic [6:0]          cap_q;
  logic [FW-1:0]       fill_q, fill_d;
  logic [31:0]         stamp_q, stamp_d;
  logic [KW-1:0]       clr_q, clr_d;
  logic                cmd_q, cmd_d;
  logic [KEY_BITS-1:0] rem_q, rem_d;
  logic [31:0]         div_q, div_d;
  logic [3:0]          step_q, step_d;
  logic [31:0]         val_q, val_d;
  logic                ins_q, ins_d;
  logic [HW-1:0]       s_q, s_d;
  logic [KW-1:0]       e_key_q, e_key_d;
  lfu_rank_t           e_rank_q, e_rank_d;
  logic [KW-1:0]       l_key_q, l_key_d;
  lfu_rank_t           l_rank_q, l_rank_d;
  logic [KW-1:0]       m_key_q, m_key_d;
  lfu_rank_t           m_rank_q, m_rank_d;
  logic [HW-1:0]       m_slot_q, m_slot_d;

  logic [KW-1:0] kt_addr;
  lfu_kt_wr_t    kt_wr;
  logic [31:0]   kt_wvalue;
  logic [HW-1:0] kt_wslot;
  logic          kt_valid;
  logic [31:0]   kt_value;
  logic [HW-1:0] kt_slot;

  logic [HW-1:0] hp_addr;
  logic          hp_we;
  logic [KW-1:0] hp_wkey;
  lfu_rank_t     hp_wrank;
  logic [KW-1:0] hp_key;
  lfu_rank_t     hp_rank;

  lfu_rank_t cmp_a, cmp_b;
  logic      below;

  logic [CW-1:0] c_left, c_right, fill_c;
  logic [HW-1:0] parent;
  logic [PW-1:0] cap_eff, fill_p;
  logic          accept;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);

  assign c_left  = {1'b0, s_q, 1'b1};
  assign c_right = c_left + CW'(1);
  assign fill_c  = CW'(fill_q);
  assign parent  = HW'((s_q - HW'(1)) >> 1);
  assign fill_p  = PW'(fill_q);
  assign cap_eff = (PW'(cap_q) > PW'(HEAP_DEPTH)) ? PW'(HEAP_DEPTH) : PW'(cap_q);

  lfu_key_table #(
    .KEY_SPACE (KEY_SPACE),
    .KW        (KW),
    .HW        (HW)
  ) u_keys (
    .clk_i   (clk_i),
    .addr_i  (kt_addr),
    .wr_i    (kt_wr),
    .value_i (kt_wvalue),
    .slot_i  (kt_wslot),
    .valid_o (kt_valid),
    .value_o (kt_value),
    .slot_o  (kt_slot)
  );

  lfu_heap_ram #(
    .DEPTH (HEAP_DEPTH),
    .AW    (HW),
    .KW    (KW)
  ) u_heap (
    .clk_i  (clk_i),
    .addr_i (hp_addr),
    .we_i   (hp_we),
    .key_i  (hp_wkey),
    .rank_i (hp_wrank),
    .key_o  (hp_key),
    .rank_o (hp_rank)
  );

  lfu_rank_cmp u_cmp (
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .below_o (below)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == CLR_LAST) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_d = (32'(cmd_i.key) >= 32'(KEY_SPACE)) ? ST_MOD : ST_LK_RD;
        end
      end
      ST_MOD:    if (step_q == 4'd0) state_d = ST_LK_RD;
      ST_LK_RD:  state_d = ST_LK_CHK;
      ST_LK_CHK: begin
        if (kt_valid) begin
          state_d = ST_TOUCH;
        end else if (cmd_q == CMD_GET || cap_eff == '0) begin
          state_d = ST_IDLE;
        end else if (fill_p >= cap_eff) begin
          state_d = ST_EV_RD;
        end else begin
          state_d = ST_INS;
        end
      end
      ST_TOUCH:  state_d = ST_SK_C;
      ST_EV_RD:  state_d = ST_EV_V;
      ST_EV_V:   state_d = ST_EV_L;
      ST_EV_L:   state_d = (fill_q != '0) ? ST_SK_C : ST_INS;
      ST_INS:    state_d = ST_RS_C;
      ST_SK_C:   state_d = (c_left >= fill_c) ? ST_SK_END : ST_SK_L;
      ST_SK_L:   state_d = (c_right < fill_c) ? ST_SK_R : ST_SK_CMP;
      ST_SK_R:   state_d = ST_SK_CMP;
      ST_SK_CMP: state_d = below ? ST_SK_C : ST_SK_END;
      ST_SK_END: state_d = ins_q ? ST_INS : ST_IDLE;
      ST_RS_C:   state_d = (s_q == '0) ? ST_RS_END : ST_RS_P;
      ST_RS_P:   state_d = below ? ST_RS_C : ST_RS_END;
      ST_RS_END: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    kt_addr        = KW'(rem_q);
    kt_wr          = '0;
    kt_wvalue      = val_q;
    kt_wslot       = s_q;
    hp_addr        = s_q;
    hp_we          = 1'b0;
    hp_wkey        = e_key_q;
    hp_wrank       = e_rank_q;
    cmp_a          = m_rank_q;
    cmp_b          = e_rank_q;
    result_valid_o = 1'b0;
    result_o.hit        = kt_valid;
    result_o.read_value = kt_valid ? kt_value : MISS_VALUE;
    case (state_q)
      ST_CLEAR: begin
        kt_addr        = clr_q;
        kt_wr.valid_we = 1'b1;
        kt_wr.valid    = 1'b0;
      end
      ST_LK_CHK: begin
        result_valid_o = (cmd_q == CMD_GET);
        kt_wr.value_we = kt_valid && (cmd_q == CMD_PUT);
        hp_addr        = kt_slot;
      end
      ST_EV_RD:  hp_addr = '0;
      ST_EV_V: begin
        kt_addr        = hp_key;
        kt_wr.valid_we = 1'b1;
        kt_wr.valid    = 1'b0;
        hp_addr        = HW'(fill_q - FW'(1));
      end
      ST_INS: begin
        kt_wr.valid_we = 1'b1;
        kt_wr.valid    = 1'b1;
        kt_wr.value_we = 1'b1;
      end
      ST_SK_C:  hp_addr = c_left[HW-1:0];
      ST_SK_L:  hp_addr = c_right[HW-1:0];
      ST_SK_R: begin
        cmp_a = hp_rank;
        cmp_b = l_rank_q;
      end
      ST_SK_CMP: begin
        if (below) begin
          hp_we         = 1'b1;
          hp_wkey       = m_key_q;
          hp_wrank      = m_rank_q;
          kt_addr       = m_key_q;
          kt_wr.slot_we = 1'b1;
        end
      end
      ST_SK_END, ST_RS_END: begin
        hp_we         = 1'b1;
        kt_addr       = e_key_q;
        kt_wr.slot_we = 1'b1;
      end
      ST_RS_C:  hp_addr = parent;
      ST_RS_P: begin
        cmp_a = e_rank_q;
        cmp_b = hp_rank;
        if (below) begin
          hp_we         = 1'b1;
          hp_wkey       = hp_key;
          hp_wrank      = hp_rank;
          kt_addr       = hp_key;
          kt_wr.slot_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    fill_d   = fill_q;
    stamp_d  = stamp_q;
    clr_d    = clr_q;
    cmd_d    = cmd_q;
    rem_d    = rem_q;
    div_d    = div_q;
    step_d   = step_q;
    val_d    = val_q;
    ins_d    = ins_q;
    s_d      = s_q;
    e_key_d  = e_key_q;
    e_rank_d = e_rank_q;
    l_key_d  = l_key_q;
    l_rank_d = l_rank_q;
    m_key_d  = m_key_q;
    m_rank_d = m_rank_q;
    m_slot_d = m_slot_q;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + KW'(1);
      ST_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_i.command;
          rem_d   = cmd_i.key;
          val_d   = cmd_i.value;
          step_d  = 4'd1;
          stamp_d = (stamp_q == SAT_MAX) ? stamp_q : stamp_q + 32'd1;
        end
      end
      ST_MOD: begin
        if (step_q != 4'd0) begin
          div_d = (32'(rem_q) * RECIP) >> MOD_SHIFT;
        end else begin
          rem_d = rem_q - KEY_BITS'(div_q * 32'(KEY_SPACE));
        end
        step_d = step_q - 4'd1;
      end
      ST_LK_CHK: s_d = kt_slot;
      ST_TOUCH: begin
        ins_d          = 1'b0;
        e_key_d        = KW'(rem_q);
        e_rank_d.count = (hp_rank.count == SAT_MAX) ? SAT_MAX : hp_rank.count + 32'd1;
        e_rank_d.stamp = stamp_q;
      end
      ST_EV_V:  fill_d = fill_q - FW'(1);
      ST_EV_L: begin
        e_key_d  = hp_key;
        e_rank_d = hp_rank;
        s_d      = '0;
        ins_d    = 1'b1;
      end
      ST_INS: begin
        e_key_d        = KW'(rem_q);
        e_rank_d.count = 32'd1;
        e_rank_d.stamp = stamp_q;
        s_d            = HW'(fill_q);
      end
      ST_SK_L: begin
        l_key_d  = hp_key;
        l_rank_d = hp_rank;
        m_key_d  = hp_key;
        m_rank_d = hp_rank;
        m_slot_d = c_left[HW-1:0];
      end
      ST_SK_R: begin
        if (below) begin
          m_key_d  = hp_key;
          m_rank_d = hp_rank;
          m_slot_d = c_right[HW-1:0];
        end else begin
          m_key_d  = l_key_q;
          m_rank_d = l_rank_q;
          m_slot_d = c_left[HW-1:0];
        end
      end
      ST_SK_CMP: if (below) s_d = m_slot_q;
      ST_RS_P:   if (below) s_d = parent;
      ST_RS_END: fill_d = fill_q + FW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cap_q   <= 7'd64;
      fill_q  <= '0;
      stamp_q <= '0;
      clr_q   <= '0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      stamp_q <= stamp_d;
      clr_q   <= clr_d;
      ins_q   <= ins_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
    step_q   <= step_d;
    val_q    <= val_d;
    s_q      <= s_d;
    e_key_q  <= e_key_d;
    e_rank_q <= e_rank_d;
    l_key_q  <= l_key_d;
    l_rank_q <= l_rank_d;
    m_key_q  <= m_key_d;
    m_rank_q <= m_rank_d;
    m_slot_q <= m_slot_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(HEAP_DEPTH))
    else $error("heap fill beyond depth");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result beat outside an item");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beat repeated");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> busy || $past(state_q) == ST_RS_END)
    else $error("fill changed while idle");

endmodule

### tb/testbench.sv
// Self-checking testbench for lfu_cache_heap: directed table then random get/put beats,
// every result checked against typed row values or an LFU predictor with LRU tiebreak.
// Depends on lfu_pkg and the lfu_cache_heap RTL.
`timescale 1ns / 1ps

module testbench;
  import lfu_pkg::*;

  localparam int unsigned KEYS = 4096;
  localparam int unsigned SLOTS = 64;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned SETTLE = 64;

  typedef struct {
    bit          is_cfg;
    bit          cmd;
    bit [11:0]   key;
    bit [31:0]   value;
    bit          chk;
    bit          exp_hit;
    bit [31:0]   exp_val;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  lfu_in_t cmd_i = '0;
  logic result_valid_o;
  lfu_out_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [6:0] cfg_data_i = '0;

  lfu_cache_heap i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted cache state
  bit          key_valid [KEYS];
  bit [31:0]   key_value [KEYS];
  bit [31:0]   key_count [KEYS];
  bit [31:0]   key_stamp [KEYS];
  int unsigned key_slot [KEYS];
  bit [11:0]   heap_key [SLOTS];
  int unsigned heap_fill;
  bit [31:0]   now_stamp;
  bit [6:0]    capacity;

  lfu_out_t    pending_reads[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  function automatic bit ranks_first(int unsigned a, int unsigned b);
    if (key_count[a] != key_count[b]) return key_count[a] < key_count[b];
    return key_stamp[a] < key_stamp[b];
  endfunction

  function automatic void seat(int unsigned slot, int unsigned k);
    heap_key[slot] = 12'(k);
    key_slot[k] = slot;
  endfunction

  function automatic void sink_down(int unsigned slot, int unsigned k, int unsigned fill);
    int unsigned c;
    forever begin
      c = slot * 2 + 1;
      if (c >= fill) break;
      if (c + 1 < fill && ranks_first(heap_key[c + 1], heap_key[c])) c++;
      if (!ranks_first(heap_key[c], k)) break;
      seat(slot, heap_key[c]);
      slot = c;
    end
    seat(slot, k);
  endfunction

  function automatic void rise_up(int unsigned slot, int unsigned k);
    int unsigned p;
    while (slot != 0) begin
      p = (slot - 1) / 2;
      if (!ranks_first(k, heap_key[p])) break;
      seat(slot, heap_key[p]);
      slot = p;
    end
    seat(slot, k);
  endfunction

  function automatic void bump_use(int unsigned k);
    key_stamp[k] = now_stamp;
    if (key_count[k] != SAT_MAX) key_count[k]++;
    sink_down(key_slot[k], k, heap_fill);
  endfunction

  // apply one beat to the predicted cache; returns 1 when a read result is due
  function automatic bit cache_apply(lfu_in_t it, output lfu_out_t rd);
    int unsigned k;
    int unsigned cap;
    int unsigned last;
    k = it.key;
    cap = (capacity > SLOTS) ? SLOTS : capacity;
    rd = '0;
    if (now_stamp != SAT_MAX) now_stamp++;
    if (it.command == CMD_GET) begin
      if (!key_valid[k]) begin
        rd.hit = 1'b0;
        rd.read_value = MISS_VALUE;
        return 1'b1;
      end
      bump_use(k);
      rd.hit = 1'b1;
      rd.read_value = key_value[k];
      return 1'b1;
    end
    if (key_valid[k]) begin
      key_value[k] = it.value;
      bump_use(k);
      return 1'b0;
    end
    if (cap == 0) return 1'b0;
    if (heap_fill >= cap) begin
      key_valid[heap_key[0]] = 1'b0;
      heap_fill--;
      last = heap_key[heap_fill];
      if (heap_fill != 0) sink_down(0, last, heap_fill);
    end
    key_valid[k] = 1'b1;
    key_value[k] = it.value;
    key_stamp[k] = now_stamp;
    key_count[k] = 1;
    rise_up(heap_fill, k);
    heap_fill++;
    return 1'b0;
  endfunction

  always @(posedge clk_i) begin
    lfu_out_t want;
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_ni && result_valid_o) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result beat: hit=%0b read_value=%0h", result_o.hit,
               result_o.read_value);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (result_o.hit !== want.hit) begin
          $error("hit: expected %0b, actual %0b", want.hit, result_o.hit);
          errors++;
        end
        if (result_o.read_value !== want.read_value) begin
          $error("read_value: expected %0h, actual %0h", want.read_value,
                 result_o.read_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain_reads();
    while (pending_reads.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(bit [6:0] c);
    start <= 1'b0;
    drain_reads();
    repeat (SETTLE) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= c;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    capacity = c;
  endtask

  // drive one beat, hold until taken, then optionally idle
  task automatic issue(lfu_in_t it, bit use_pred, lfu_out_t typed, int unsigned gap);
    lfu_out_t rd;
    start <= 1'b1;
    cmd_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (cache_apply(it, rd)) pending_reads.push_back(use_pred ? rd : typed);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic lfu_in_t random_beat();
    lfu_in_t it;
    it.command = 1'($urandom_range(0, 1));
    it.key = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 23));
    it.value = $urandom;
    return it;
  endfunction

  dir_row_t dir_rows [] = '{
    '{0, CMD_GET, 12'd0,    32'h0,         1, 0, MISS_VALUE},
    '{0, CMD_GET, 12'd4095, 32'h0,         1, 0, MISS_VALUE},
    '{0, CMD_PUT, 12'd0,    32'h7FFF_FFFF, 0, 0, 32'h0},
    '{0, CMD_PUT, 12'd4095, 32'h8000_0000, 0, 0, 32'h0},
    '{0, CMD_GET, 12'd0,    32'h0,         1, 1, 32'h7FFF_FFFF},
    '{0, CMD_GET, 12'd4095, 32'hFFFF_FFFF, 1, 1, 32'h8000_0000},
    '{0, CMD_PUT, 12'd0,    32'h0,         0, 0, 32'h0},
    '{0, CMD_GET, 12'd0,    32'h0,         1, 1, 32'h0},
    '{1, CMD_GET, 12'd0,    32'd0,         0, 0, 32'h0},
    '{0, CMD_PUT, 12'd100,  32'd5,         0, 0, 32'h0},
    '{0, CMD_GET, 12'd100,  32'h0,         1, 0, MISS_VALUE},
    '{0, CMD_PUT, 12'd4095, 32'hFFFF_FFFF, 0, 0, 32'h0},
    '{0, CMD_GET, 12'd4095, 32'h0,         1, 1, 32'hFFFF_FFFF},
    '{1, CMD_GET, 12'd0,    32'd1,         0, 0, 32'h0},
    '{0, CMD_PUT, 12'd200,  32'd7,         0, 0, 32'h0},
    '{0, CMD_GET, 12'd0,    32'h0,         0, 0, 32'h0},
    '{0, CMD_GET, 12'd4095, 32'h0,         0, 0, 32'h0},
    '{0, CMD_GET, 12'd200,  32'h0,         0, 0, 32'h0},
    '{1, CMD_GET, 12'd0,    32'd127,       0, 0, 32'h0},
    '{0, CMD_PUT, 12'd300,  32'd1,         0, 0, 32'h0},
    '{0, CMD_PUT, 12'd301,  32'd2,         0, 0, 32'h0},
    '{0, CMD_GET, 12'd300,  32'h0,         0, 0, 32'h0},
    '{0, CMD_PUT, 12'd302,  32'd3,         0, 0, 32'h0},
    '{0, CMD_GET, 12'd301,  32'h0,         0, 0, 32'h0},
    '{1, CMD_GET, 12'd0,    32'd2,         0, 0, 32'h0},
    '{0, CMD_PUT, 12'd303,  32'd4,         0, 0, 32'h0},
    '{0, CMD_GET, 12'd303,  32'h0,         0, 0, 32'h0},
    '{0, CMD_GET, 12'd300,  32'h0,         0, 0, 32'h0}
  };

  bit [6:0] phase_caps [8] = '{7'd64, 7'd3, 7'd0, 7'd127, 7'd1, 7'd2, 7'd16, 7'd8};

  initial begin
    lfu_in_t it;
    lfu_out_t typed;
    int unsigned gap;
    capacity = 7'd64;
    heap_fill = 0;
    now_stamp = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_capacity(dir_rows[i].value[6:0]);
      end else begin
        it.command = dir_rows[i].cmd;
        it.key = dir_rows[i].key;
        it.value = dir_rows[i].value;
        typed.hit = dir_rows[i].exp_hit;
        typed.read_value = dir_rows[i].exp_val;
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0;
        issue(it, !dir_rows[i].chk, typed, gap);
      end
    end
    start <= 1'b0;

    foreach (phase_caps[p]) begin
      write_capacity((p == 7) ? 7'($urandom_range(0, 127)) : phase_caps[p]);
      for (int n = 0; n < 106; n++) begin
        it = random_beat();
        if (p == 7 || $urandom_range(0, 3) != 0) gap = 0;
        else gap = $urandom_range(1, 14);
        issue(it, 1'b1, typed, gap);
        if (p == 2 && n == 50) begin
          start <= 1'b0;
          drain_reads();
        end
      end
      start <= 1'b0;
    end

    for (int w = 0; w < IDLE_LIMIT && pending_reads.size() != 0; w++) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
